// ===== hw/rtl/cc20_pkg.sv =====
// Shared types, constants and helpers for the ChaCha20 stream cipher.
// No dependencies; imported by every other file of the block but cc20_qr.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam int DATA_W  = 64;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 64;
    localparam int BUF_WORDS = 8;
    localparam int POS_W   = 3;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT      = 3'd7;

    // sixteen 32-bit state words, word 0 in bits 31:0
    typedef logic [15:0][31:0] cc_state_t;
    typedef logic [BUF_WORDS-1:0][DATA_W-1:0] cc_buf_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cc_core_stat_t;

    // byte enable mask for the first cnt bytes of a word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (COUNT_W'(i) < cnt)
            begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/cc20_ifs.sv =====
// Valid/ready channel interfaces for message items and result items.
// Depends on cc20_pkg for field widths.
interface cc20_msg_if;
    import cc20_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  in_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               first;

    modport source (output valid, output in_bytes, output byte_count, output first,
                    input ready);
    modport sink   (input valid, input in_bytes, input byte_count, input first,
                    output ready);
endinterface

interface cc20_res_if;
    import cc20_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  out_bytes;
    logic [COUNT_W-1:0] out_count;

    modport source (output valid, output out_bytes, output out_count, input ready);
    modport sink   (input valid, input out_bytes, input out_count, output ready);
endinterface

// ===== hw/rtl/cc20_qr.sv =====
// One ChaCha quarter-round lane, combinational.
// No package dependencies.
module cc20_qr (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);
    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic [31:0] t0, t1, t2, t3;

    always_comb
    begin
        a1 = a + b;
        t0 = d ^ a1;
        d1 = {t0[15:0], t0[31:16]};
        c1 = c + d1;
        t1 = b ^ c1;
        b1 = {t1[19:0], t1[31:20]};
        a2 = a1 + b1;
        t2 = d1 ^ a2;
        d2 = {t2[23:0], t2[31:24]};
        c2 = c1 + d2;
        t3 = b1 ^ c2;
        b2 = {t3[24:0], t3[31:25]};
    end

    assign a_out = a2;
    assign b_out = b2;
    assign c_out = c2;
    assign d_out = d2;
endmodule

// ===== hw/rtl/cc20_core.sv =====
// Block function: four quarter-round lanes run one round per cycle, then a
// merge stage adds the input state back in. Depends on cc20_pkg, cc20_qr.
module cc20_core #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cc20_pkg::cc_state_t     init,
    output cc20_pkg::cc_state_t     ks,
    output cc20_pkg::cc_core_stat_t stat
);
    import cc20_pkg::*;

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RW = $clog2(ROUNDS);
    localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS - 1);

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

    core_state_t state_reg, state_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic done_reg, done_next;
    cc_state_t x_reg, x_next, init_reg, ks_reg, ks_sum, x_round;

    logic [3:0][3:0][31:0] lane_in;
    logic [3:0][3:0][31:0] lane_out;
    logic diag;

    assign diag = rnd_reg[0];

    // lane i row r: column round takes column i, diagonal round shifts by row
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            assign lane_in[i][r] = diag ? x_reg[r*4 + ((i + r) % 4)] : x_reg[r*4 + i];
        end
        cc20_qr u_qr (
            .a     (lane_in[i][0]),
            .b     (lane_in[i][1]),
            .c     (lane_in[i][2]),
            .d     (lane_in[i][3]),
            .a_out (lane_out[i][0]),
            .b_out (lane_out[i][1]),
            .c_out (lane_out[i][2]),
            .d_out (lane_out[i][3])
        );
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_wb_row
        for (genvar k = 0; k < 4; k++)
        begin : g_wb_col
            assign x_round[r*4 + k] = diag ? lane_out[(k - r + 4) % 4][r] : lane_out[k][r];
            assign ks_sum[r*4 + k]  = x_reg[r*4 + k] + init_reg[r*4 + k];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next     = init;
                    rnd_next   = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                x_next = x_round;
                if (rnd_reg == LAST_RND)
                begin
                    state_next = C_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            C_ADD:
            begin
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            done_reg  <= done_next;
        end
    end

    // datapath words, no reset
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (state_reg == C_IDLE && start)
        begin
            init_reg <= init;
        end
        if (state_reg == C_ADD)
        begin
            ks_reg <= ks_sum;
        end
    end

    assign ks        = ks_reg;
    assign stat.done = done_reg;
    assign stat.busy = (state_reg != C_IDLE);
endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher top level: config registers, keystream buffer,
// message sequencing and result register. Depends on cc20_pkg, cc20_ifs,
// cc20_core.
//
// Usage: write key, nonce, start counter and layout through the cfg port
// while idle. Each msg item carries up to 8 bytes; the res item returns
// them XORed with the next 8 keystream bytes (bytes past the count read 0).
// Set first on the opening item of a message; an item shorter than 8 bytes
// ends the message.
// An item served from the buffered block gives its result in the cycle after
// acceptance, and items can follow each cycle while res takes them. An item that
// needs a new block goes through load, one round per cycle in the four
// quarter-round lanes, feed-forward add, buffer load and result write; msg.ready
// stays low meanwhile, so no new item is taken until that result is written.
// Reset clears the config registers, block counter, buffer state and
// result register. If res is stalled, the finished result holds in the
// output register and msg.ready stays low until the slot frees up.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cc20_msg_if.sink                       msg,
    cc20_res_if.source                     res,
    input  logic                           cfg_write,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cc20_pkg::CFG_W-1:0]     cfg_data
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_GEN, S_EMIT} top_state_t;

    top_state_t state_reg, state_next;

    logic [3:0][63:0] key_reg;
    logic [63:0] nonce_low_reg, ctr_start_reg;
    logic [31:0] nonce_high_reg;
    logic        layout_reg;

    logic [63:0]        ctr_reg, ctr_next;
    logic               bvalid_reg, bvalid_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]  data_reg;
    logic [COUNT_W-1:0] cnt_reg;
    cc_buf_t            buf_reg;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_bytes_reg, out_bytes_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic               slot_free, accept, need_blk, core_start;
    logic [COUNT_W-1:0] in_cnt;
    logic               bvalid_eff;
    logic [63:0]        ctr_raw, ctr_use, ctr_inc;
    cc_state_t          init_state, ks_words;
    cc_core_stat_t      core_stat;

    logic               emit;
    logic [DATA_W-1:0]  emit_data, emit_ks;
    logic [COUNT_W-1:0] emit_cnt;
    logic [POS_W-1:0]   emit_pos, emit_pos_inc;

    assign slot_free = !out_valid_reg || res.ready;
    assign msg.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = msg.valid && msg.ready;

    assign in_cnt     = msg.byte_count[3] ? FULL_COUNT : msg.byte_count;
    assign bvalid_eff = bvalid_reg && !msg.first;
    assign need_blk   = (in_cnt != '0) && !bvalid_eff;
    assign core_start = accept && need_blk;

    // counter seen by the next block, kept to 32 bits in the 96-bit nonce layout
    assign ctr_raw = msg.first ? ctr_start_reg : ctr_reg;
    assign ctr_use = layout_reg ? {32'h0, ctr_raw[31:0]} : ctr_raw;
    assign ctr_inc = layout_reg ? {32'h0, ctr_reg[31:0] + 32'd1} : ctr_reg + 64'd1;

    always_comb
    begin
        init_state[0] = SIGMA0;
        init_state[1] = SIGMA1;
        init_state[2] = SIGMA2;
        init_state[3] = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init_state[4 + 2*i] = key_reg[i][31:0];
            init_state[5 + 2*i] = key_reg[i][63:32];
        end
        init_state[12] = ctr_use[31:0];
        if (layout_reg)
        begin
            init_state[13] = nonce_low_reg[31:0];
            init_state[14] = nonce_low_reg[63:32];
            init_state[15] = nonce_high_reg;
        end
        else
        begin
            init_state[13] = ctr_use[63:32];
            init_state[14] = nonce_low_reg[31:0];
            init_state[15] = nonce_low_reg[63:32];
        end
    end

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .init  (init_state),
        .ks    (ks_words),
        .stat  (core_stat)
    );

    // result path: straight from the buffer when idle, from word 0 after a new block
    assign emit_data    = (state_reg == S_EMIT) ? data_reg : msg.in_bytes;
    assign emit_cnt     = (state_reg == S_EMIT) ? cnt_reg : in_cnt;
    assign emit_pos     = (state_reg == S_EMIT) ? '0 : pos_reg;
    assign emit_ks      = buf_reg[emit_pos];
    assign emit_pos_inc = emit_pos + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        bvalid_next    = bvalid_reg;
        pos_next       = pos_reg;
        emit           = 1'b0;
        out_valid_next = out_valid_reg && !res.ready;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (msg.first)
                    begin
                        ctr_next = ctr_use;
                    end
                    if (in_cnt == '0)
                    begin
                        bvalid_next    = 1'b0;
                        pos_next       = '0;
                        out_valid_next = 1'b1;
                        out_bytes_next = '0;
                        out_count_next = '0;
                    end
                    else if (need_blk)
                    begin
                        ctr_next   = ctr_use;
                        state_next = S_GEN;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            S_GEN:
            begin
                if (core_stat.done)
                begin
                    ctr_next   = ctr_inc;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = (emit_data ^ emit_ks) & byte_mask(emit_cnt);
            out_count_next = emit_cnt;
            // drop the block when used up or when a short item ends the message
            if (emit_pos_inc == '0 || emit_cnt != FULL_COUNT)
            begin
                bvalid_next = 1'b0;
                pos_next    = '0;
            end
            else
            begin
                bvalid_next = 1'b1;
                pos_next    = emit_pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ctr_reg        <= '0;
            bvalid_reg     <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_bytes_reg  <= '0;
            out_count_reg  <= '0;
            key_reg        <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            ctr_start_reg  <= '0;
            layout_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            bvalid_reg    <= bvalid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_bytes_reg <= out_bytes_next;
            out_count_reg <= out_count_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEY0:       key_reg[0]     <= cfg_data;
                    REG_KEY1:       key_reg[1]     <= cfg_data;
                    REG_KEY2:       key_reg[2]     <= cfg_data;
                    REG_KEY3:       key_reg[3]     <= cfg_data;
                    REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                    REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                    REG_COUNTER:    ctr_start_reg  <= cfg_data;
                    REG_LAYOUT:     layout_reg     <= cfg_data[0];
                    default:        layout_reg     <= layout_reg;
                endcase
            end
        end
    end

    // payload holding registers, no reset
    always_ff @(posedge clk)
    begin
        if (core_start)
        begin
            data_reg <= msg.in_bytes;
            cnt_reg  <= in_cnt;
        end
        if (state_reg == S_GEN && core_stat.done)
        begin
            for (int i = 0; i < BUF_WORDS; i++)
            begin
                buf_reg[i] <= {ks_words[2*i + 1], ks_words[2*i]};
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_bytes = out_bytes_reg;
    assign res.out_count = out_count_reg;

    a_done_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == S_GEN)
        else $error("core finished a block outside the generate state");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_start |=> core_stat.busy && state_reg == S_GEN)
        else $error("block generation did not start after a fresh-block item");

    a_pos_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != '0 |-> bvalid_reg)
        else $error("word position advanced with no valid keystream block");

    a_res_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.out_bytes & ~byte_mask(res.out_count)) == '0)
        else $error("result bytes beyond the count are not zero");
endmodule

// ===== tb/sv/cc20_keystream_checker.sv =====
// Checker for the ChaCha20 stream cipher: mirrors the config registers, predicts
// each cipher word from accepted msg items and compares it with res items.
// Depends on cc20_pkg and the channel interfaces in cc20_ifs.
module cc20_keystream_checker #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cc20_msg_if                            msg,
    cc20_res_if                            res,
    input  logic                           cfg_write,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cc20_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             checked
);
    import cc20_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  text;
        logic [COUNT_W-1:0] nbytes;
    } cipher_word_t;

    logic [63:0]       key_reg [4];
    logic [63:0]       nonce_lo;
    logic [31:0]       nonce_hi;
    logic [63:0]       ctr_start;
    logic              layout_reg;

    logic [63:0]       blk_ctr;
    logic [DATA_W-1:0] ks_buf [BUF_WORDS];
    logic [POS_W-1:0]  word_pos;
    logic              buf_ok;

    cipher_word_t      expected_words[$];
    int                err_cnt;
    int                n_checked;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic cc_state_t quarter_round(input cc_state_t x, input int a, b, c, d);
        x[a] = x[a] + x[b];
        x[d] = rotl(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d];
        x[b] = rotl(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b];
        x[d] = rotl(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d];
        x[b] = rotl(x[b] ^ x[c], 7);
        return x;
    endfunction

    function automatic void make_keystream_block();
        cc_state_t init;
        cc_state_t w;
        init[0] = SIGMA0;
        init[1] = SIGMA1;
        init[2] = SIGMA2;
        init[3] = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        if (layout_reg)
        begin
            blk_ctr[63:32] = '0;
            init[12] = blk_ctr[31:0];
            init[13] = nonce_lo[31:0];
            init[14] = nonce_lo[63:32];
            init[15] = nonce_hi;
        end
        else
        begin
            init[12] = blk_ctr[31:0];
            init[13] = blk_ctr[63:32];
            init[14] = nonce_lo[31:0];
            init[15] = nonce_lo[63:32];
        end
        w = init;
        repeat (DOUBLE_ROUNDS)
        begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < BUF_WORDS; i++)
        begin
            ks_buf[i] = {w[2 * i + 1] + init[2 * i + 1], w[2 * i] + init[2 * i]};
        end
        blk_ctr = blk_ctr + 64'd1;
        if (layout_reg)
        begin
            blk_ctr[63:32] = '0;
        end
        word_pos = '0;
        buf_ok = 1'b1;
    endfunction

    function automatic void predict_cipher_word(input logic [DATA_W-1:0] data,
                                                input logic [COUNT_W-1:0] cnt_in,
                                                input logic first_flag);
        logic [COUNT_W-1:0] cnt;
        logic [DATA_W-1:0]  mask;
        cipher_word_t       r;
        cnt = (cnt_in > FULL_COUNT) ? FULL_COUNT : cnt_in;
        if (first_flag)
        begin
            blk_ctr = layout_reg ? {32'h0, ctr_start[31:0]} : ctr_start;
            buf_ok = 1'b0;
            word_pos = '0;
        end
        if (cnt == '0)
        begin
            // empty item still closes the message
            buf_ok = 1'b0;
            word_pos = '0;
            r.text = '0;
            r.nbytes = '0;
        end
        else
        begin
            if (!buf_ok)
            begin
                make_keystream_block();
            end
            mask = (cnt == FULL_COUNT) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
            r.text = (data ^ ks_buf[word_pos]) & mask;
            r.nbytes = cnt;
            word_pos = word_pos + 1'b1;
            // drop the rest of the block when it wraps or the message ends short
            if (word_pos == '0 || cnt < FULL_COUNT)
            begin
                buf_ok = 1'b0;
                word_pos = '0;
            end
        end
        expected_words.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h, expected %h", what, $time, got, want);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] = '0;
            end
            nonce_lo = '0;
            nonce_hi = '0;
            ctr_start = '0;
            layout_reg = 1'b0;
            blk_ctr = '0;
            word_pos = '0;
            buf_ok = 1'b0;
            expected_words.delete();
            err_cnt = 0;
            n_checked = 0;
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_write === 1'b1)
            begin
                case (cfg_index)
                    REG_KEY0:       key_reg[0] = cfg_data;
                    REG_KEY1:       key_reg[1] = cfg_data;
                    REG_KEY2:       key_reg[2] = cfg_data;
                    REG_KEY3:       key_reg[3] = cfg_data;
                    REG_NONCE_LOW:  nonce_lo = cfg_data;
                    REG_NONCE_HIGH: nonce_hi = cfg_data[31:0];
                    REG_COUNTER:    ctr_start = cfg_data;
                    REG_LAYOUT:     layout_reg = cfg_data[0];
                    default:        ;
                endcase
            end
            if (msg.valid === 1'b1 && msg.ready === 1'b1)
            begin
                predict_cipher_word(msg.in_bytes, msg.byte_count, msg.first);
            end
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                n_checked++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch("result with nothing pending", res.out_bytes, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (res.out_bytes !== want.text)
                    begin
                        report_mismatch("out_bytes", res.out_bytes, want.text);
                    end
                    if (res.out_count !== want.nbytes)
                    begin
                        report_mismatch("out_count", 64'(res.out_count), 64'(want.nbytes));
                    end
                end
            end
            mismatches <= err_cnt;
            outstanding <= expected_words.size();
            checked <= n_checked;
        end
    end

endmodule

// ===== tb/sv/chacha20_stream_cipher_tb.sv =====
// Top of the ChaCha20 stream cipher testbench: clock, reset, config writes,
// message stimulus and random stalls. Depends on cc20_pkg, cc20_ifs, the
// block itself and cc20_keystream_checker.
module chacha20_stream_cipher_tb;
    import cc20_pkg::*;

    localparam int DR = DOUBLE_ROUNDS_DEF;
    localparam int SEGMENTS = 6;
    localparam int SEGMENT_ITEMS = 250;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int src_idle_pct;
    int snk_idle_pct;
    int items_sent;
    int settings_used;

    cc20_msg_if msg_ch();
    cc20_res_if res_ch();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS(DR)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .msg(msg_ch),
        .res(res_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cc20_keystream_checker #(
        .DOUBLE_ROUNDS(DR)
    ) keystream_chk (
        .clk(clk),
        .rst_n(rst_n),
        .msg(msg_ch),
        .res(res_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .checked(checked)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial
    begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // bias toward zero words (raw keystream) and all-ones words
    function automatic logic [DATA_W-1:0] message_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            return '0;
        end
        if (pick < 15)
        begin
            return '1;
        end
        return rand64();
    endfunction

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct = 29;
                snk_idle_pct = 51;
            end
            1:
            begin
                src_idle_pct = 51;
                snk_idle_pct = 29;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_cipher(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic [63:0] n_lo, input logic [31:0] n_hi,
                                  input logic [63:0] ctr, input logic layout);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE_LOW, n_lo);
        write_reg(REG_NONCE_HIGH, {32'h0, n_hi});
        write_reg(REG_COUNTER, ctr);
        write_reg(REG_LAYOUT, {63'h0, layout});
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic program_segment(input int seg);
        logic [63:0] ctr;
        case (seg)
            // 32-bit counter loaded from an all-ones value: masked, then wraps
            0: program_cipher('1, '1, '1, '1, '1, 32'hffff_ffff, '1, 1'b1);
            // 64-bit counter wraps within the first long message
            1: program_cipher('0, '0, '0, '0, '0, 32'h0, 64'hffff_ffff_ffff_fffe, 1'b0);
            default:
            begin
                ctr = $urandom_range(1) ? {$urandom, 29'h1fff_ffff, 3'($urandom)} : rand64();
                program_cipher(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                               ctr, seg[0]);
            end
        endcase
    endtask

    task automatic send_item(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] cnt,
                             input logic first_flag);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.in_bytes <= data;
        msg_ch.byte_count <= cnt;
        msg_ch.first <= first_flag;
        @(posedge clk);
        while (msg_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // full items, then usually a short item that closes the message
    task automatic send_message(input logic opener);
        int unsigned n_full;
        logic        first_flag;
        n_full = $urandom_range(20);
        first_flag = opener;
        repeat (n_full)
        begin
            send_item(message_word(), FULL_COUNT, first_flag);
            first_flag = 1'b0;
        end
        if ($urandom_range(99) < 70)
        begin
            send_item(message_word(), COUNT_W'($urandom_range(1, 7)), first_flag);
        end
    endtask

    // hold until every predicted word has come back
    task automatic drain();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int goal;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        msg_ch.valid <= 1'b0;
        msg_ch.in_bytes <= '0;
        msg_ch.byte_count <= '0;
        msg_ch.first <= 1'b0;
        items_sent = 0;
        settings_used = 0;
        set_idle(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_cipher(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, 64'h0, 1'b0);
        // one whole block, raw keystream first, then the next block
        send_item('0, FULL_COUNT, 1'b1);
        for (int i = 0; i < 7; i++)
        begin
            send_item(i[0] ? '0 : '1, FULL_COUNT, 1'b0);
        end
        send_item('0, FULL_COUNT, 1'b0);
        send_item(rand64(), 4'd1, 1'b0);
        // no first after a short item: fresh block at the advanced counter
        send_item(rand64(), FULL_COUNT, 1'b0);
        send_item(rand64(), 4'd7, 1'b0);
        send_item(rand64(), 4'd0, 1'b0);
        send_item(rand64(), 4'd15, 1'b0);
        send_item(rand64(), 4'd9, 1'b1);
        send_item(rand64(), 4'd0, 1'b1);
        for (int c = 2; c <= 6; c++)
        begin
            send_item(rand64(), COUNT_W'(c), 1'b0);
        end
        send_item('1, FULL_COUNT, 1'b1);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            set_idle(seg / 2);
            program_segment(seg);
            goal = items_sent + SEGMENT_ITEMS;
            // carry on the previous message under the new setting
            send_message(1'b0);
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 12)
                begin
                    send_item(rand64(), COUNT_W'($urandom_range(15)), 1'($urandom_range(1)));
                end
                else
                begin
                    send_message($urandom_range(99) < 85);
                end
            end
            drain();
        end
        repeat (2 * DR + 8) @(posedge clk);

        $display("Covered %0d message items over %0d key/nonce/counter settings in both layouts,",
                 items_sent, settings_used);
        $display("including counter wrap, empty and oversized counts; %0d words compared.",
                 checked);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
